FILE: rtl/core/bnfc_pkg.sv
// ----------------------------------------------------------------------------
// bnfc_pkg
// Shared types and constants for the binary navigation frame checker.
// ----------------------------------------------------------------------------
package bnfc_pkg;

    // Default payload size limit.
    localparam int DEF_MAX_PAYLOAD = 128;

    // Frame header bytes and known message ids.
    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam logic [7:0] CLASS_NAV   = 8'h01;
    localparam logic [7:0] ID_SHORT    = 8'd1;
    localparam logic [7:0] ID_LONG     = 8'd7;

    // Register reset values.
    localparam logic [7:0] SHORT_LEN_RST = 8'd20;
    localparam logic [7:0] LONG_LEN_RST  = 8'd92;

    // Configuration register map.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_LEN = 1'b0,
        CFG_LONG_LEN  = 1'b1
    } t_cfg_idx;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SYNC2,
        PH_CLASS,
        PH_ID,
        PH_LEN,
        PH_PAYLOAD,
        PH_CKA,
        PH_CKB
    } t_phase;

    // Result kinds.
    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_kind;

    // Frame status codes.
    typedef enum logic [2:0] {
        ST_ACCEPTED   = 3'd0,
        ST_GOOD_SHORT = 3'd1,
        ST_CKSUM_ERR  = 3'd2,
        ST_UNKNOWN_ID = 3'd3,
        ST_BAD_HEADER = 3'd4
    } t_status;

    // One result item.
    typedef struct packed {
        t_kind       kind;
        logic [6:0]  index;
        logic [7:0]  value;
        t_status     status;
        logic [7:0]  msg_id;
        logic        fix;
    } t_result;

endpackage

FILE: rtl/core/bnfc_if.sv
// ----------------------------------------------------------------------------
// bnfc_if
// Valid/ready channels for received bytes and for checker results.
// ----------------------------------------------------------------------------
interface bnfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bnfc_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [6:0] payload_index;
    logic [7:0] payload_value;
    logic [2:0] frame_status;
    logic [7:0] frame_msg_id;
    logic       fix_received;

    modport source (output valid, output result_kind, output payload_index,
                    output payload_value, output frame_status, output frame_msg_id,
                    output fix_received, input ready);
    modport sink   (input valid, input result_kind, input payload_index,
                    input payload_value, input frame_status, input frame_msg_id,
                    input fix_received, output ready);
endinterface

FILE: rtl/core/bnfc_parser.sv
// ----------------------------------------------------------------------------
// bnfc_parser
// Frame state machine with the two-sum checksum; one byte per cycle while i_accept is high.
// ----------------------------------------------------------------------------
module bnfc_parser #(
    parameter int MAX_PAYLOAD = bnfc_pkg::DEF_MAX_PAYLOAD
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_byte,
    input  logic [7:0]         i_short_len,
    input  logic [7:0]         i_long_len,
    output logic               o_res_valid,
    output bnfc_pkg::t_result  o_res
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int LEN_W = (CNT_W > 8) ? CNT_W : 8;

    bnfc_pkg::t_phase r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_sum_a, n_sum_a;
    logic [7:0]       r_sum_b, n_sum_b;
    logic [7:0]       r_id, n_id;
    logic             r_cka_ok, n_cka_ok;
    logic             r_rcv, n_rcv;

    logic [7:0]       len_sel;
    logic [LEN_W-1:0] len_ext;
    logic [LEN_W-1:0] frame_len;
    logic [LEN_W-1:0] cnt_ext;
    logic [LEN_W-1:0] cnt_inc;
    logic [7:0]       sum_a_add;
    logic [7:0]       sum_b_add;
    logic             cks_ok;

    // Payload length of the current id, limited to MAX_PAYLOAD.
    always_comb begin
        len_sel = (r_id == bnfc_pkg::ID_LONG) ? i_long_len : i_short_len;
        len_ext = LEN_W'(len_sel);
        if (len_ext > LEN_W'(MAX_PAYLOAD)) begin
            frame_len = LEN_W'(MAX_PAYLOAD);
        end else begin
            frame_len = len_ext;
        end
        cnt_ext = LEN_W'(r_cnt);
        cnt_inc = cnt_ext + LEN_W'(1);
    end

    // Running Fletcher sums including the current byte.
    assign sum_a_add = r_sum_a + i_byte;
    assign sum_b_add = r_sum_b + sum_a_add;
    assign cks_ok    = r_cka_ok && (i_byte == r_sum_b);

    // Next state and result for the accepted byte.
    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_sum_a     = r_sum_a;
        n_sum_b     = r_sum_b;
        n_id        = r_id;
        n_cka_ok    = r_cka_ok;
        n_rcv       = r_rcv;
        o_res_valid = 1'b0;
        o_res.kind   = bnfc_pkg::KIND_STATUS;
        o_res.index  = '0;
        o_res.value  = '0;
        o_res.status = bnfc_pkg::ST_ACCEPTED;
        o_res.msg_id = '0;
        o_res.fix    = r_rcv;
        if (i_accept) begin
            case (r_phase)
                bnfc_pkg::PH_HUNT: begin
                    if (i_byte == bnfc_pkg::SYNC_FIRST) begin
                        n_phase = bnfc_pkg::PH_SYNC2;
                    end
                end
                bnfc_pkg::PH_SYNC2: begin
                    if (i_byte == bnfc_pkg::SYNC_SECOND) begin
                        n_phase = bnfc_pkg::PH_CLASS;
                    end else begin
                        n_rcv        = 1'b0;
                        n_phase      = bnfc_pkg::PH_HUNT;
                        o_res_valid  = 1'b1;
                        o_res.status = bnfc_pkg::ST_BAD_HEADER;
                        o_res.fix    = 1'b0;
                    end
                end
                bnfc_pkg::PH_CLASS: begin
                    if (i_byte == bnfc_pkg::CLASS_NAV) begin
                        // Sums restart with the class byte.
                        n_sum_a = i_byte;
                        n_sum_b = i_byte;
                        n_phase = bnfc_pkg::PH_ID;
                    end else begin
                        n_rcv        = 1'b0;
                        n_phase      = bnfc_pkg::PH_HUNT;
                        o_res_valid  = 1'b1;
                        o_res.status = bnfc_pkg::ST_BAD_HEADER;
                        o_res.fix    = 1'b0;
                    end
                end
                bnfc_pkg::PH_ID: begin
                    n_id = i_byte;
                    if (i_byte != bnfc_pkg::ID_SHORT && i_byte != bnfc_pkg::ID_LONG) begin
                        n_rcv        = 1'b0;
                        n_phase      = bnfc_pkg::PH_HUNT;
                        o_res_valid  = 1'b1;
                        o_res.status = bnfc_pkg::ST_UNKNOWN_ID;
                        o_res.msg_id = i_byte;
                        o_res.fix    = 1'b0;
                    end else begin
                        n_sum_a = sum_a_add;
                        n_sum_b = sum_b_add;
                        n_cnt   = '0;
                        n_phase = bnfc_pkg::PH_LEN;
                    end
                end
                bnfc_pkg::PH_LEN: begin
                    // The counter marks which of the two length bytes this is.
                    n_sum_a = sum_a_add;
                    n_sum_b = sum_b_add;
                    if (r_cnt == '0) begin
                        n_cnt = CNT_W'(1);
                    end else begin
                        n_cnt   = '0;
                        n_phase = (frame_len == '0) ? bnfc_pkg::PH_CKA
                                                    : bnfc_pkg::PH_PAYLOAD;
                    end
                end
                bnfc_pkg::PH_PAYLOAD: begin
                    n_sum_a      = sum_a_add;
                    n_sum_b      = sum_b_add;
                    n_cnt        = CNT_W'(cnt_inc);
                    o_res_valid  = 1'b1;
                    o_res.kind   = bnfc_pkg::KIND_PAYLOAD;
                    o_res.index  = cnt_ext[6:0];
                    o_res.value  = i_byte;
                    o_res.msg_id = r_id;
                    if (cnt_inc >= frame_len) begin
                        n_phase = bnfc_pkg::PH_CKA;
                    end
                end
                bnfc_pkg::PH_CKA: begin
                    n_cka_ok = (i_byte == r_sum_a);
                    n_phase  = bnfc_pkg::PH_CKB;
                end
                bnfc_pkg::PH_CKB: begin
                    n_rcv        = cks_ok && (r_id == bnfc_pkg::ID_LONG);
                    n_phase      = bnfc_pkg::PH_HUNT;
                    o_res_valid  = 1'b1;
                    o_res.msg_id = r_id;
                    o_res.fix    = n_rcv;
                    if (!cks_ok) begin
                        o_res.status = bnfc_pkg::ST_CKSUM_ERR;
                    end else if (r_id == bnfc_pkg::ID_LONG) begin
                        o_res.status = bnfc_pkg::ST_ACCEPTED;
                    end else begin
                        o_res.status = bnfc_pkg::ST_GOOD_SHORT;
                    end
                end
                default: begin
                    n_phase = bnfc_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= bnfc_pkg::PH_HUNT;
            r_cnt    <= '0;
            r_sum_a  <= '0;
            r_sum_b  <= '0;
            r_id     <= '0;
            r_cka_ok <= 1'b0;
            r_rcv    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_sum_a  <= n_sum_a;
            r_sum_b  <= n_sum_b;
            r_id     <= n_id;
            r_cka_ok <= n_cka_ok;
            r_rcv    <= n_rcv;
        end
    end

endmodule

FILE: rtl/core/bnfc_out_buf.sv
// ----------------------------------------------------------------------------
// bnfc_out_buf
// Two-entry result buffer: an output register backed by a skid register.
// ----------------------------------------------------------------------------
module bnfc_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bnfc_pkg::t_result  i_data,
    output logic               o_ready,
    output logic               o_valid,
    output bnfc_pkg::t_result  o_data,
    input  logic               i_out_ready
);

    logic              r_out_v, n_out_v;
    logic              r_skid_v, n_skid_v;
    bnfc_pkg::t_result r_out, n_out;
    bnfc_pkg::t_result r_skid, n_skid;
    logic              pop;

    // New bytes are taken as long as the skid register is free.
    assign o_ready = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;
    assign pop     = r_out_v && i_out_ready;

    // Fill and drain of the two entries.
    always_comb begin
        n_out_v  = r_out_v;
        n_skid_v = r_skid_v;
        n_out    = r_out;
        n_skid   = r_skid;
        if (pop) begin
            if (r_skid_v) begin
                n_out    = r_skid;
                n_skid_v = 1'b0;
            end else begin
                n_out_v = 1'b0;
            end
        end
        if (i_push) begin
            if (!r_out_v || pop) begin
                n_out   = i_data;
                n_out_v = 1'b1;
            end else begin
                n_skid   = i_data;
                n_skid_v = 1'b1;
            end
        end
    end

    // Valid flags take reset; data registers do not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

FILE: rtl/core/binary_nav_frame_checker_top.sv
// ----------------------------------------------------------------------------
// binary_nav_frame_checker_top
// Byte-serial checker for class 0x01 navigation frames with Fletcher-8 sums.
// ----------------------------------------------------------------------------
// The checker takes one received byte per clock cycle while the result side
// keeps up. Each byte is handled in a single pass through the frame state
// machine and its result, if any, is registered, so a payload byte or a frame
// status appears on the result channel in the cycle after the byte transfer at
// the earliest. Results wait in a two-entry buffer. A result that arrives
// while the first entry is stalled goes to the second entry, and input ready
// is low while that entry is full, so a result-side stall pauses the byte
// stream from the cycle after a result enters the second entry until the
// cycle after the stall ends.
// Frame lengths come from the two length registers (index 0 for id 1,
// index 1 for id 7), limited to MAX_PAYLOAD; write them only while idle.
module binary_nav_frame_checker_top #(
    parameter int MAX_PAYLOAD = bnfc_pkg::DEF_MAX_PAYLOAD
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bnfc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bnfc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bnfc_in_if.sink                       i_rx,
    bnfc_out_if.source                    o_res
);

    logic              r_short_len;
    logic [7:0]        r_short, r_long;
    logic              accept;
    logic              buf_ready;
    logic              res_valid;
    bnfc_pkg::t_result res;
    bnfc_pkg::t_result out_data;

    // Length registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short <= bnfc_pkg::SHORT_LEN_RST;
            r_long  <= bnfc_pkg::LONG_LEN_RST;
        end else if (i_cfg_we) begin
            case (bnfc_pkg::t_cfg_idx'(i_cfg_idx))
                bnfc_pkg::CFG_SHORT_LEN: r_short <= i_cfg_data;
                bnfc_pkg::CFG_LONG_LEN:  r_long  <= i_cfg_data;
                default: begin
                    r_short <= r_short;
                end
            endcase
        end
    end

    // Flags a short-frame length register write; used by the write check below.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_len <= 1'b0;
        end else begin
            r_short_len <= i_cfg_we && (i_cfg_idx == bnfc_pkg::CFG_SHORT_LEN);
        end
    end

    // Byte transfer.
    assign i_rx.ready = buf_ready;
    assign accept     = i_rx.valid && buf_ready;

    bnfc_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_rx.rx_byte),
        .i_short_len (r_short),
        .i_long_len  (r_long),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    bnfc_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_data      (res),
        .o_ready     (buf_ready),
        .o_valid     (o_res.valid),
        .o_data      (out_data),
        .i_out_ready (o_res.ready)
    );

    // Result channel payload.
    assign o_res.result_kind   = out_data.kind;
    assign o_res.payload_index = out_data.index;
    assign o_res.payload_value = out_data.value;
    assign o_res.frame_status  = out_data.status;
    assign o_res.frame_msg_id  = out_data.msg_id;
    assign o_res.fix_received  = out_data.fix;

    // A bad header status never carries a message id.
    a_bad_hdr_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && out_data.kind == bnfc_pkg::KIND_STATUS &&
        out_data.status == bnfc_pkg::ST_BAD_HEADER |-> out_data.msg_id == 8'd0)
        else $error("bad header status with nonzero message id");

    // Only an accepted long frame may leave the received flag set.
    a_fix_only_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && out_data.kind == bnfc_pkg::KIND_STATUS &&
        out_data.status != bnfc_pkg::ST_ACCEPTED |-> !out_data.fix)
        else $error("received flag set after a frame that was not accepted");

    // A payload result carries a zero status.
    a_payload_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && out_data.kind == bnfc_pkg::KIND_PAYLOAD |->
        out_data.status == bnfc_pkg::ST_ACCEPTED)
        else $error("payload result with nonzero status");

    // A short-frame length write lands in the short register on the next edge.
    a_cfg_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_short_len |-> r_short == $past(i_cfg_data))
        else $error("short frame length write lost");

    // A result only follows a byte transfer.
    a_res_after_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> accept)
        else $error("result produced without a byte transfer");

endmodule
